// ===== hdl/qts_pkg.sv =====
// Shared types, codes and constants for the quoted token splitter.
`timescale 1ns / 1ps

package qts_pkg;

  localparam int unsigned CharW    = 8;
  localparam int unsigned KindW    = 3;
  localparam int unsigned LenW     = 12;
  localparam int unsigned CapW     = 13;
  localparam int unsigned CfgIdxW  = 3;
  localparam int unsigned CfgDataW = 13;
  localparam int unsigned OutDataW = 24;

  localparam int unsigned ResFifoDepth = 4;

  localparam logic [CfgIdxW-1:0] REG_SEP_A    = 3'd0;
  localparam logic [CfgIdxW-1:0] REG_SEP_B    = 3'd1;
  localparam logic [CfgIdxW-1:0] REG_QUOTE    = 3'd2;
  localparam logic [CfgIdxW-1:0] REG_QUOTE_EN = 3'd3;
  localparam logic [CfgIdxW-1:0] REG_CAPACITY = 3'd4;

  localparam logic [KindW-1:0] KIND_CHAR     = 3'd0;
  localparam logic [KindW-1:0] KIND_TEND     = 3'd1;
  localparam logic [KindW-1:0] KIND_LEND     = 3'd2;
  localparam logic [KindW-1:0] KIND_LONG     = 3'd3;
  localparam logic [KindW-1:0] KIND_UNCLOSED = 3'd4;

  localparam logic [1:0] PH_SKIP    = 2'd0;
  localparam logic [1:0] PH_TOKEN   = 2'd1;
  localparam logic [1:0] PH_DISCARD = 2'd2;

  localparam logic [CapW-1:0] CAP_MIN = 13'd2;
  localparam logic [CapW-1:0] CAP_MAX = 13'd4096;

  localparam logic [CharW-1:0] SEP_A_RST    = 8'd32;
  localparam logic [CharW-1:0] SEP_B_RST    = 8'd9;
  localparam logic [CharW-1:0] QUOTE_RST    = 8'd34;
  localparam logic [CapW-1:0]  CAPACITY_RST = 13'd256;

  typedef struct packed {
    logic [KindW-1:0] kind;
    logic [CharW-1:0] data;
    logic [LenW-1:0]  token_length;
    logic             last;
  } res_t;

  typedef struct packed {
    logic [CharW-1:0] sep_a;
    logic [CharW-1:0] sep_b;
    logic [CharW-1:0] quote;
    logic             quote_en;
    logic [CapW-1:0]  capacity;
  } cfg_t;

  typedef struct packed {
    logic [1:0] phase;
    logic       quoting;
  } status_t;

  typedef struct packed {
    logic [1:0] count;
    res_t       res0;
    res_t       res1;
  } step_t;

endpackage

// ===== hdl/qts_core.sv =====
// Per-byte tokenizer step logic with phase, quote and length state.
`timescale 1ns / 1ps

module qts_core (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      step_i,
  input  logic [qts_pkg::CharW-1:0] char_i,
  input  qts_pkg::cfg_t             cfg_i,
  output qts_pkg::step_t            step_o,
  output qts_pkg::status_t          status_o
);

  logic [1:0]                phase_q, phase_d;
  logic                      quoting_q, quoting_d;
  logic [qts_pkg::LenW-1:0]  count_q, count_d;

  logic                      sep;
  logic                      is_quote;
  logic                      base_quoting;
  logic [qts_pkg::LenW-1:0]  base_count;
  logic [qts_pkg::CapW-1:0]  count_inc;
  logic [qts_pkg::CapW-1:0]  eff_cap;

  assign sep      = (char_i == cfg_i.sep_a) || (char_i == cfg_i.sep_b);
  assign is_quote = cfg_i.quote_en && (char_i == cfg_i.quote);

  assign base_quoting = (phase_q == qts_pkg::PH_TOKEN) ? quoting_q : 1'b0;
  assign base_count   = (phase_q == qts_pkg::PH_TOKEN) ? count_q : '0;
  assign count_inc    = {1'b0, base_count} + qts_pkg::CapW'(1);

  always_comb begin
    if (cfg_i.capacity < qts_pkg::CAP_MIN) begin
      eff_cap = qts_pkg::CAP_MIN;
    end else if (cfg_i.capacity > qts_pkg::CAP_MAX) begin
      eff_cap = qts_pkg::CAP_MAX;
    end else begin
      eff_cap = cfg_i.capacity;
    end
  end

  always_comb begin
    step_o    = '0;
    phase_d   = phase_q;
    quoting_d = quoting_q;
    count_d   = count_q;
    if (phase_q == qts_pkg::PH_DISCARD) begin
      if (char_i == '0) begin
        phase_d   = qts_pkg::PH_SKIP;
        quoting_d = 1'b0;
        count_d   = '0;
      end
    end else if (char_i == '0) begin
      if (phase_q == qts_pkg::PH_TOKEN && quoting_q) begin
        step_o.count     = 2'd1;
        step_o.res0.kind = qts_pkg::KIND_UNCLOSED;
        step_o.res0.last = 1'b1;
      end else if (phase_q == qts_pkg::PH_TOKEN) begin
        step_o.count             = 2'd2;
        step_o.res0.kind         = qts_pkg::KIND_TEND;
        step_o.res0.token_length = count_q;
        step_o.res1.kind         = qts_pkg::KIND_LEND;
        step_o.res1.last         = 1'b1;
      end else begin
        step_o.count     = 2'd1;
        step_o.res0.kind = qts_pkg::KIND_LEND;
        step_o.res0.last = 1'b1;
      end
      phase_d   = qts_pkg::PH_SKIP;
      quoting_d = 1'b0;
      count_d   = '0;
    end else if (!(phase_q != qts_pkg::PH_TOKEN && sep)) begin
      phase_d   = qts_pkg::PH_TOKEN;
      quoting_d = base_quoting;
      count_d   = base_count;
      if (is_quote) begin
        quoting_d = ~base_quoting;
      end else if (sep && !base_quoting) begin
        step_o.count             = 2'd1;
        step_o.res0.kind         = qts_pkg::KIND_TEND;
        step_o.res0.token_length = base_count;
        step_o.res0.last         = 1'b1;
        phase_d                  = qts_pkg::PH_SKIP;
        quoting_d                = 1'b0;
        count_d                  = '0;
      end else begin
        step_o.res0.kind = qts_pkg::KIND_CHAR;
        step_o.res0.data = char_i;
        if (count_inc >= eff_cap) begin
          step_o.count     = 2'd2;
          step_o.res1.kind = qts_pkg::KIND_LONG;
          step_o.res1.last = 1'b1;
          phase_d          = qts_pkg::PH_DISCARD;
          quoting_d        = 1'b0;
          count_d          = '0;
        end else begin
          step_o.count     = 2'd1;
          step_o.res0.last = 1'b1;
          count_d          = count_inc[qts_pkg::LenW-1:0];
        end
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q   <= qts_pkg::PH_SKIP;
      quoting_q <= 1'b0;
      count_q   <= '0;
    end else if (step_i) begin
      phase_q   <= phase_d;
      quoting_q <= quoting_d;
      count_q   <= count_d;
    end
  end

  assign status_o.phase   = phase_q;
  assign status_o.quoting = quoting_q;

endmodule

// ===== hdl/qts_res_fifo.sv =====
// Result queue taking up to two results per cycle and returning one while ready_i is high.
`timescale 1ns / 1ps

module qts_res_fifo #(
  parameter int unsigned Depth = qts_pkg::ResFifoDepth
) (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            push_i,
  input  qts_pkg::step_t  step_i,
  output logic            room_o,
  output logic            valid_o,
  input  logic            ready_i,
  output qts_pkg::res_t   res_o
);

  localparam int unsigned PtrW = (Depth > 1) ? $clog2(Depth) : 1;
  localparam int unsigned CntW = $clog2(Depth + 1);

  qts_pkg::res_t     mem_q [Depth];
  logic [PtrW-1:0]   rd_ptr_q, rd_ptr_d;
  logic [PtrW-1:0]   wr_ptr_q, wr_ptr_d;
  logic [PtrW-1:0]   wr_ptr_nx;
  logic [CntW-1:0]   count_q, count_d;
  logic [CntW-1:0]   count_left;
  logic              pop;
  logic [1:0]        n_push;

  function automatic logic [PtrW-1:0] ptr_inc(input logic [PtrW-1:0] p);
    logic [PtrW-1:0] r;
    if (p == PtrW'(Depth - 1)) begin
      r = '0;
    end else begin
      r = p + PtrW'(1);
    end
    return r;
  endfunction

  assign pop        = valid_o && ready_i;
  assign count_left = count_q - CntW'(pop);
  assign room_o     = count_left <= CntW'(Depth - 2);
  assign n_push     = push_i ? step_i.count : 2'd0;
  assign wr_ptr_nx  = ptr_inc(wr_ptr_q);

  always_comb begin
    rd_ptr_d = pop ? ptr_inc(rd_ptr_q) : rd_ptr_q;
    count_d  = count_left + CntW'(n_push);
    case (n_push)
      2'd1:    wr_ptr_d = wr_ptr_nx;
      2'd2:    wr_ptr_d = ptr_inc(wr_ptr_nx);
      default: wr_ptr_d = wr_ptr_q;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      rd_ptr_q <= '0;
      wr_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      rd_ptr_q <= rd_ptr_d;
      wr_ptr_q <= wr_ptr_d;
      count_q  <= count_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (n_push != 2'd0) begin
      mem_q[wr_ptr_q] <= step_i.res0;
    end
    if (n_push == 2'd2) begin
      mem_q[wr_ptr_nx] <= step_i.res1;
    end
  end

  assign valid_o = count_q != '0;
  assign res_o   = mem_q[rd_ptr_q];

endmodule

// ===== hdl/quoted_token_splitter_unit.sv =====
// Quoted token splitter top level: input register, config registers, core, result queue.
// Each byte goes through the input register, then its results enter the result queue.
// Throughput: one byte per cycle while the result queue has room; bytes with two results
// fill the queue faster than the single-result output port drains it, then hold input.
// Reset: rst_ni clears control state, sets registers to space, tab, double quote, quoting on,
// capacity 256, and returns the tokenizer to skipping separators.
`timescale 1ns / 1ps

module quoted_token_splitter_unit #(
  parameter int unsigned ResFifoDepth = qts_pkg::ResFifoDepth
) (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         s_axis_tvalid,
  output logic                         s_axis_tready,
  input  logic [qts_pkg::CharW-1:0]    s_axis_tdata,   // [7:0] char_in
  output logic                         m_axis_tvalid,
  input  logic                         m_axis_tready,
  output logic [qts_pkg::OutDataW-1:0] m_axis_tdata,   // [7:0] data, [19:8] token_length
  output logic [qts_pkg::KindW-1:0]    m_axis_tuser,   // [2:0] kind
  output logic                         m_axis_tlast,
  input  logic                         cfg_we_i,
  input  logic [qts_pkg::CfgIdxW-1:0]  cfg_idx_i,
  input  logic [qts_pkg::CfgDataW-1:0] cfg_data_i
);

  qts_pkg::cfg_t               cfg_q;
  logic                        in_valid_q;
  logic [qts_pkg::CharW-1:0]   in_char_q;
  logic                        step;
  logic                        room;
  qts_pkg::step_t              step_res;
  qts_pkg::status_t            status;
  qts_pkg::res_t               head;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.sep_a    <= qts_pkg::SEP_A_RST;
      cfg_q.sep_b    <= qts_pkg::SEP_B_RST;
      cfg_q.quote    <= qts_pkg::QUOTE_RST;
      cfg_q.quote_en <= 1'b1;
      cfg_q.capacity <= qts_pkg::CAPACITY_RST;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        qts_pkg::REG_SEP_A:    cfg_q.sep_a    <= cfg_data_i[qts_pkg::CharW-1:0];
        qts_pkg::REG_SEP_B:    cfg_q.sep_b    <= cfg_data_i[qts_pkg::CharW-1:0];
        qts_pkg::REG_QUOTE:    cfg_q.quote    <= cfg_data_i[qts_pkg::CharW-1:0];
        qts_pkg::REG_QUOTE_EN: cfg_q.quote_en <= cfg_data_i[0];
        qts_pkg::REG_CAPACITY: cfg_q.capacity <= cfg_data_i[qts_pkg::CapW-1:0];
        default: ;
      endcase
    end
  end

  assign step          = in_valid_q && room;
  assign s_axis_tready = !in_valid_q || room;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tready && s_axis_tvalid) begin
      in_char_q <= s_axis_tdata;
    end
  end

  qts_core u_core (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .step_i   (step),
    .char_i   (in_char_q),
    .cfg_i    (cfg_q),
    .step_o   (step_res),
    .status_o (status)
  );

  qts_res_fifo #(
    .Depth (ResFifoDepth)
  ) u_res_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (step),
    .step_i  (step_res),
    .room_o  (room),
    .valid_o (m_axis_tvalid),
    .ready_i (m_axis_tready),
    .res_o   (head)
  );

  assign m_axis_tdata = {4'b0000, head.token_length, head.data};
  assign m_axis_tuser = head.kind;
  assign m_axis_tlast = head.last;

`ifndef ASSERT_OFF
  a_discard_unquoted: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (status.phase == qts_pkg::PH_DISCARD) |-> !status.quoting)
    else $error("quoting set while discarding");

  a_pair_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && step_res.count == 2'd2) |-> (step_res.res1.last && !step_res.res0.last))
    else $error("two-result request has wrong last marking");

  a_result_shows: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (step && step_res.count != 2'd0) |=> m_axis_tvalid)
    else $error("result request not presented");
`endif

endmodule
